// ----- rtl/core/vcpd_pkg.sv -----
// Package for the voxel column pole detector: grid sizes, field widths, payload
// structs, command and state codes shared by the front, back and run scanner.
// Depends on nothing.
package vcpd_pkg;

	// Grid geometry.
	localparam int GRID_X      = 64;
	localparam int GRID_Y      = 64;
	localparam int GRID_Z      = 32;
	localparam int NUM_COLUMNS = GRID_X * GRID_Y;
	localparam int COL_IDX_W   = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

	// Field widths fixed by the interface.
	localparam int FUNC_W    = 2;
	localparam int X_W       = 6;
	localparam int Y_W       = 6;
	localparam int Z_W       = 5;
	localparam int SPAN_W    = 5;
	localparam int CFG_IDX_W = 2;

	// Run scanner: a few column bits are examined per cycle.
	localparam int SCAN_BITS  = 4;
	localparam int SCAN_STEPS = (GRID_Z + SCAN_BITS - 1) / SCAN_BITS;
	localparam int SCAN_LEN   = SCAN_STEPS * SCAN_BITS;
	localparam int POS_W      = $clog2(SCAN_LEN);
	localparam int STEP_W     = (SCAN_STEPS > 1) ? $clog2(SCAN_STEPS) : 1;

	// Command queue between front and back, and result queue behind the back.
	localparam int CMD_DEPTH = 2;
	localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
	localparam int RES_DEPTH = 2;
	localparam int RES_PTR_W = (RES_DEPTH > 1) ? $clog2(RES_DEPTH) : 1;
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// Operation codes on the func field.
	localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

	// Configuration register indexes and reset values.
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPAN = 2'd1;
	localparam logic [SPAN_W-1:0]    MIN_SPAN_RST = 5'd4;
	localparam logic [SPAN_W-1:0]    MAX_SPAN_RST = 5'd31;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [X_W-1:0]    grid_x;
		logic [Y_W-1:0]    grid_y;
		logic [Z_W-1:0]    grid_z;
	} in_item_t;

	typedef struct packed {
		logic           determined;
		logic           is_pole;
		logic [Z_W-1:0] run_start;
		logic [Z_W-1:0] run_end;
	} out_item_t;

	typedef struct packed {
		logic [SPAN_W-1:0] min_span;
		logic [SPAN_W-1:0] max_span;
	} cfg_t;

	// Classified command handed from the front to the back.
	typedef enum logic [1:0] {
		OP_NOP,
		OP_INSERT,
		OP_QUERY,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [COL_IDX_W-1:0] col;
		logic [Z_W-1:0]       z;
	} cmd_t;

	// Back end sequencer states.
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_READ,
		BK_SCAN
	} bk_state_t;

	// Outcome of a column scan.
	typedef struct packed {
		logic             any;
		logic [POS_W-1:0] lowest;
		logic [POS_W-1:0] best;
		logic [POS_W-1:0] rs;
		logic [POS_W-1:0] re;
	} scan_res_t;

endpackage

// ----- rtl/core/vcpd_front.sv -----
// Front end of the pole detector: accepts input beats, classifies them into
// commands and holds them in a two-entry command queue. Uses vcpd_pkg.
module vcpd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  vcpd_pkg::in_item_t item,
	input  logic            clearing,
	output logic            cmd_valid,
	output vcpd_pkg::cmd_t  cmd,
	input  logic            cmd_pop
);

	vcpd_pkg::cmd_t                 cmd_q [vcpd_pkg::CMD_DEPTH];
	logic [vcpd_pkg::CMD_PTR_W-1:0] wr_ptr_q;
	logic [vcpd_pkg::CMD_PTR_W-1:0] rd_ptr_q;
	logic [vcpd_pkg::CMD_CNT_W-1:0] cnt_q;
	vcpd_pkg::cmd_t                 cls;
	logic                           col_ok;
	logic                           z_ok;
	logic                           accept;
	logic                           take;

	// Classify the beat: anything that leaves the grid untouched and answers
	// with zeros becomes a no-op.
	always_comb begin
		col_ok  = (int'(item.grid_x) < vcpd_pkg::GRID_X) &&
		          (int'(item.grid_y) < vcpd_pkg::GRID_Y);
		z_ok    = int'(item.grid_z) < vcpd_pkg::GRID_Z;
		cls.col = vcpd_pkg::COL_IDX_W'(int'(item.grid_x) * vcpd_pkg::GRID_Y +
		                               int'(item.grid_y));
		cls.z   = item.grid_z;
		unique case (item.func)
			vcpd_pkg::FUNC_INSERT: cls.op = (col_ok && z_ok) ? vcpd_pkg::OP_INSERT
			                                                 : vcpd_pkg::OP_NOP;
			vcpd_pkg::FUNC_QUERY:  cls.op = col_ok ? vcpd_pkg::OP_QUERY : vcpd_pkg::OP_NOP;
			vcpd_pkg::FUNC_CLEAR:  cls.op = col_ok ? vcpd_pkg::OP_CLEAR : vcpd_pkg::OP_NOP;
			default:               cls.op = vcpd_pkg::OP_NOP;
		endcase
	end

	assign full      = (cnt_q == vcpd_pkg::CMD_CNT_W'(vcpd_pkg::CMD_DEPTH)) || clearing;
	assign accept    = push && !full;
	assign cmd_valid = cnt_q != '0;
	assign take      = cmd_pop && cmd_valid;
	assign cmd       = cmd_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= (wr_ptr_q == vcpd_pkg::CMD_PTR_W'(vcpd_pkg::CMD_DEPTH - 1)) ?
				            '0 : wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= (rd_ptr_q == vcpd_pkg::CMD_PTR_W'(vcpd_pkg::CMD_DEPTH - 1)) ?
				            '0 : rd_ptr_q + 1'b1;
			end
			if (accept && !take) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take && !accept) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q[wr_ptr_q] <= cls;
		end
	end

endmodule

// ----- rtl/core/vcpd_scan.sv -----
// Iterative run scanner: walks a column word a few bits per cycle and finds
// its longest occupied run, later runs winning ties. Uses vcpd_pkg.
module vcpd_scan (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [vcpd_pkg::GRID_Z-1:0] word,
	output logic                      done,
	output vcpd_pkg::scan_res_t       res
);

	logic                            busy_q;
	logic                            done_q;
	logic [vcpd_pkg::STEP_W-1:0]     step_q;
	logic [vcpd_pkg::SCAN_LEN-1:0]   word_q;
	logic [vcpd_pkg::POS_W-1:0]      pos_q;
	logic [vcpd_pkg::POS_W-1:0]      cur_q;
	vcpd_pkg::scan_res_t             res_q;
	logic [vcpd_pkg::POS_W-1:0]      cur_d;
	vcpd_pkg::scan_res_t             res_d;

	// One window of bits; cur tracks the start of the run being walked.
	always_comb begin
		logic [vcpd_pkg::POS_W-1:0] p;
		logic [vcpd_pkg::POS_W-1:0] span;
		cur_d = cur_q;
		res_d = res_q;
		for (int k = 0; k < vcpd_pkg::SCAN_BITS; k++) begin
			p    = pos_q + vcpd_pkg::POS_W'(k);
			span = p - cur_d;
			if (word_q[k]) begin
				if (!res_d.any) begin
					res_d.any    = 1'b1;
					res_d.lowest = p;
					res_d.best   = span;
					res_d.rs     = cur_d;
					res_d.re     = p;
				end else if (span >= res_d.best) begin
					res_d.best = span;
					res_d.rs   = cur_d;
					res_d.re   = p;
				end
			end else begin
				cur_d = p + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == vcpd_pkg::STEP_W'(vcpd_pkg::SCAN_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			word_q <= vcpd_pkg::SCAN_LEN'(word);
			pos_q  <= '0;
			cur_q  <= '0;
			res_q  <= '0;
		end else if (busy_q) begin
			word_q <= word_q >> vcpd_pkg::SCAN_BITS;
			pos_q  <= pos_q + vcpd_pkg::POS_W'(vcpd_pkg::SCAN_BITS);
			cur_q  <= cur_d;
			res_q  <= res_d;
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- rtl/core/vcpd_back.sv -----
// Back end of the pole detector: column memory with its clearing pass, the
// command sequencer, the pole test and the result queue. Uses vcpd_pkg, vcpd_scan.
module vcpd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  vcpd_pkg::cfg_t   cfg,
	output logic             clearing,
	input  logic             cmd_valid,
	input  vcpd_pkg::cmd_t   cmd,
	output logic             cmd_pop,
	output vcpd_pkg::out_item_t result,
	output logic             empty,
	input  logic             pop
);

	vcpd_pkg::bk_state_t                state_q;
	vcpd_pkg::bk_state_t                state_d;
	logic [vcpd_pkg::COL_IDX_W-1:0]     clr_cnt_q;
	vcpd_pkg::cmd_t                     cur_q;

	logic [vcpd_pkg::GRID_Z-1:0]        mem [vcpd_pkg::NUM_COLUMNS];
	logic                               mem_we;
	logic [vcpd_pkg::COL_IDX_W-1:0]     mem_waddr;
	logic [vcpd_pkg::GRID_Z-1:0]        mem_wdata;
	logic                               mem_re;
	logic [vcpd_pkg::GRID_Z-1:0]        rd_data_q;

	logic                               scan_start;
	logic                               scan_done;
	vcpd_pkg::scan_res_t                scan_res;
	logic                               pole;

	vcpd_pkg::out_item_t                res_q [vcpd_pkg::RES_DEPTH];
	logic [vcpd_pkg::RES_PTR_W-1:0]     res_wr_q;
	logic [vcpd_pkg::RES_PTR_W-1:0]     res_rd_q;
	logic [vcpd_pkg::RES_CNT_W-1:0]     res_cnt_q;
	logic                               res_full;
	logic                               res_push;
	logic                               res_take;
	vcpd_pkg::out_item_t                res_data;

	vcpd_scan u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.start (scan_start),
		.word  (rd_data_q),
		.done  (scan_done),
		.res   (scan_res)
	);

	assign pole = scan_res.any && (scan_res.rs == scan_res.lowest) &&
	              (scan_res.best >= cfg.min_span) && (scan_res.best <= cfg.max_span);

	assign clearing = state_q == vcpd_pkg::BK_CLEAR;
	assign res_full = res_cnt_q == vcpd_pkg::RES_CNT_W'(vcpd_pkg::RES_DEPTH);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			vcpd_pkg::BK_CLEAR: begin
				if (clr_cnt_q == vcpd_pkg::COL_IDX_W'(vcpd_pkg::NUM_COLUMNS - 1)) begin
					state_d = vcpd_pkg::BK_IDLE;
				end
			end
			vcpd_pkg::BK_IDLE: begin
				if (cmd_valid && !res_full &&
				    (cmd.op == vcpd_pkg::OP_INSERT || cmd.op == vcpd_pkg::OP_QUERY)) begin
					state_d = vcpd_pkg::BK_READ;
				end
			end
			vcpd_pkg::BK_READ: begin
				state_d = (cur_q.op == vcpd_pkg::OP_INSERT) ? vcpd_pkg::BK_IDLE
				                                            : vcpd_pkg::BK_SCAN;
			end
			vcpd_pkg::BK_SCAN: begin
				if (scan_done) begin
					state_d = vcpd_pkg::BK_IDLE;
				end
			end
			default: state_d = vcpd_pkg::BK_CLEAR;
		endcase
	end

	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = clr_cnt_q;
		mem_wdata  = '0;
		mem_re     = 1'b0;
		cmd_pop    = 1'b0;
		res_push   = 1'b0;
		res_data   = '0;
		scan_start = 1'b0;
		unique case (state_q)
			vcpd_pkg::BK_CLEAR: begin
				mem_we = 1'b1;
			end
			vcpd_pkg::BK_IDLE: begin
				if (cmd_valid && !res_full) begin
					cmd_pop = 1'b1;
					unique case (cmd.op)
						vcpd_pkg::OP_NOP: begin
							res_push = 1'b1;
						end
						vcpd_pkg::OP_CLEAR: begin
							mem_we    = 1'b1;
							mem_waddr = cmd.col;
							res_push  = 1'b1;
						end
						vcpd_pkg::OP_INSERT, vcpd_pkg::OP_QUERY: begin
							mem_re = 1'b1;
						end
						default: begin
							res_push = 1'b1;
						end
					endcase
				end
			end
			vcpd_pkg::BK_READ: begin
				if (cur_q.op == vcpd_pkg::OP_INSERT) begin
					mem_we    = 1'b1;
					mem_waddr = cur_q.col;
					mem_wdata = rd_data_q | (vcpd_pkg::GRID_Z'(1) << cur_q.z);
					res_push  = 1'b1;
				end else begin
					scan_start = 1'b1;
				end
			end
			vcpd_pkg::BK_SCAN: begin
				if (scan_done) begin
					res_push            = 1'b1;
					res_data.is_pole    = pole;
					res_data.determined = pole && (cur_q.z >= scan_res.rs) &&
					                      (cur_q.z <= scan_res.re);
					res_data.run_start  = vcpd_pkg::Z_W'(scan_res.rs);
					res_data.run_end    = vcpd_pkg::Z_W'(scan_res.re);
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= vcpd_pkg::BK_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == vcpd_pkg::BK_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
	end

	// Column memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[cmd.col];
		end
	end

	// Result queue.
	assign empty    = res_cnt_q == '0;
	assign res_take = pop && !empty;
	assign result   = res_q[res_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= '0;
			res_rd_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wr_q <= (res_wr_q == vcpd_pkg::RES_PTR_W'(vcpd_pkg::RES_DEPTH - 1)) ?
				            '0 : res_wr_q + 1'b1;
			end
			if (res_take) begin
				res_rd_q <= (res_rd_q == vcpd_pkg::RES_PTR_W'(vcpd_pkg::RES_DEPTH - 1)) ?
				            '0 : res_rd_q + 1'b1;
			end
			if (res_push && !res_take) begin
				res_cnt_q <= res_cnt_q + 1'b1;
			end else if (res_take && !res_push) begin
				res_cnt_q <= res_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			res_q[res_wr_q] <= res_data;
		end
	end

endmodule

// ----- rtl/core/voxel_column_pole_detector.sv -----
// Top level of the voxel column pole detector: configuration registers and the
// front and back halves. Uses vcpd_pkg, vcpd_front, vcpd_back.

// The detector keeps one occupancy word per grid column in a 4096 x 32 bit
// memory. After reset the memory is swept to zero, one column per cycle, and
// full stays high until the sweep is through; register writes are accepted
// at any time. Items go through one at a time in the back end, whose pace is
// set by the memory's registered read port and by the run scanner, which
// examines four column bits per cycle: a clear or an ignored item is handled
// in the idle state, an insert reads the column and then writes it back, and a
// query reads the column, loads the scanner, runs eight scan steps and then
// queues the result. A two-entry command queue in front of the back end and a
// two-entry result queue behind it let input beats arrive and results wait
// without stalling the other side. Every input beat yields exactly one result
// beat, in order; inserts, clears and unused codes give an all-zero result.
module voxel_column_pole_detector (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input queue side.
	input  logic                                push,
	output logic                                full,
	input  vcpd_pkg::in_item_t                  item,
	// Result queue side.
	output logic                                empty,
	input  logic                                pop,
	output vcpd_pkg::out_item_t                 result,
	// Configuration write channel.
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [vcpd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vcpd_pkg::SPAN_W-1:0]         cfg_data
);

	vcpd_pkg::cfg_t  cfg_q;
	logic            clearing;
	logic            cmd_valid;
	vcpd_pkg::cmd_t  cmd;
	logic            cmd_pop;

	// Registers are always writable; a write to an index past the list is
	// dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_span <= vcpd_pkg::MIN_SPAN_RST;
			cfg_q.max_span <= vcpd_pkg::MAX_SPAN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vcpd_pkg::REG_MIN_SPAN: cfg_q.min_span <= cfg_data;
				vcpd_pkg::REG_MAX_SPAN: cfg_q.max_span <= cfg_data;
				default:                cfg_q          <= cfg_q;
			endcase
		end
	end

	// The front takes beats and classifies them; it holds off while the
	// memory is still being cleared.
	vcpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.clearing (clearing),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop)
	);

	// The back carries out commands against the column memory and queues
	// the results.
	vcpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.clearing (clearing),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

// ----- tb/vcpd_pole_checker.sv -----
// Checker for the voxel column pole detector: watches the item, result and
// register beats, keeps its own occupancy grid and compares every result.
// Depends on vcpd_pkg.
module vcpd_pole_checker
	import vcpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  in_item_t             item,
	input  logic                 empty,
	input  logic                 pop,
	input  out_item_t            result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SPAN_W-1:0]    cfg_data,
	output int                   fail_count,
	output int                   pending,
	output int                   query_count,
	output int                   pole_count,
	output int                   hit_count
);

	bit   [GRID_Z-1:0] occupancy [NUM_COLUMNS];
	logic [SPAN_W-1:0] min_span_copy = MIN_SPAN_RST;
	logic [SPAN_W-1:0] max_span_copy = MAX_SPAN_RST;
	out_item_t         pending_answers [$];
	int                fails   = 0;
	int                queries = 0;
	int                poles   = 0;
	int                hits    = 0;

	assign fail_count  = fails;
	assign pending     = pending_answers.size();
	assign query_count = queries;
	assign pole_count  = poles;
	assign hit_count   = hits;

	// Longest run of a column; a later run of equal span wins.
	function automatic out_item_t answer_query(logic [GRID_Z-1:0] col, logic [Z_W-1:0] z);
		out_item_t ans;
		int        base, lowest, best, rs, re;
		bit        seen, pole;
		ans    = '0;
		base   = 0;
		lowest = 0;
		best   = 0;
		rs     = 0;
		re     = 0;
		seen   = 1'b0;
		for (int i = 0; i < GRID_Z; i++) begin
			if (col[i]) begin
				if (!seen || i - base >= best) begin
					if (!seen)
						lowest = i;
					seen = 1'b1;
					best = i - base;
					rs   = base;
					re   = i;
				end
			end else begin
				base = i + 1;
			end
		end
		if (seen) begin
			pole = (rs == lowest) && (best >= int'(min_span_copy)) &&
			       (best <= int'(max_span_copy));
			ans.is_pole    = pole;
			ans.determined = pole && (int'(z) >= rs) && (int'(z) <= re);
			ans.run_start  = Z_W'(rs);
			ans.run_end    = Z_W'(re);
		end
		return ans;
	endfunction

	function automatic out_item_t apply_item(in_item_t it);
		out_item_t            ans;
		logic [COL_IDX_W-1:0] col;
		bit                   on_grid;
		ans     = '0;
		on_grid = (int'(it.grid_x) < GRID_X) && (int'(it.grid_y) < GRID_Y);
		col     = COL_IDX_W'(int'(it.grid_x) * GRID_Y + int'(it.grid_y));
		case (it.func)
			FUNC_INSERT: begin
				if (on_grid && int'(it.grid_z) < GRID_Z)
					occupancy[col][it.grid_z] = 1'b1;
			end
			FUNC_CLEAR: begin
				if (on_grid)
					occupancy[col] = '0;
			end
			FUNC_QUERY: begin
				if (on_grid)
					ans = answer_query(occupancy[col], it.grid_z);
			end
			default: ;
		endcase
		return ans;
	endfunction

	task automatic check_field(string name, logic [Z_W-1:0] want, logic [Z_W-1:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Beats are sampled on the falling edge before the rising edge that takes
	// them, while every handshake signal is settled.
	always @(negedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_SPAN: min_span_copy = cfg_data;
					REG_MAX_SPAN: max_span_copy = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (pending_answers.size() == 0) begin
					fails++;
					$display("%0t: result expected none, got %p", $time, result);
				end else begin
					want = pending_answers.pop_front();
					check_field("determined", Z_W'(want.determined), Z_W'(result.determined));
					check_field("is_pole", Z_W'(want.is_pole), Z_W'(result.is_pole));
					check_field("run_start", want.run_start, result.run_start);
					check_field("run_end", want.run_end, result.run_end);
				end
			end
			if (push && !full) begin
				want = apply_item(item);
				pending_answers.push_back(want);
				if (item.func == FUNC_QUERY)
					queries++;
				if (want.is_pole)
					poles++;
				if (want.determined)
					hits++;
			end
		end
	end

endmodule

// ----- tb/voxel_column_pole_detector_tb.sv -----
// Testbench top for the voxel column pole detector: makes item, register and
// pop stimulus and gives the verdict. Depends on vcpd_pkg,
// voxel_column_pole_detector and vcpd_pole_checker.
module voxel_column_pole_detector_tb;
	import vcpd_pkg::*;

	// The func code that the block leaves unused; it must change nothing.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	// Random items per span setting, six settings in all.
	localparam int PHASE_ITEMS = 115;
	localparam int NUM_PHASES  = 6;
	// After this many accepted item beats the popping side holds off long
	// enough for both internal queues to fill and push to be refused.
	localparam int HOLD_AT     = 100;
	localparam int HOLD_CYCLES = 300;
	// Between these item counts neither side idles at random.
	localparam int CALM_FROM   = 300;
	localparam int CALM_TO     = 450;
	// Columns that most of the traffic of a phase goes to, so that queries
	// land on columns that were built up by earlier inserts.
	localparam int POOL        = 6;
	// Run-out after the last result; it leaves room to spare for a query in the back end.
	localparam int TAIL_CYCLES = 30;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 push      = 1'b0;
	logic                 full;
	in_item_t             item      = '0;
	logic                 empty;
	logic                 pop       = 1'b0;
	out_item_t            result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SPAN_W-1:0]    cfg_data  = '0;

	int fail_count, pending, query_count, pole_count, hit_count;
	int sent_total = 0;
	bit held       = 1'b0;

	logic [X_W-1:0] pool_x [POOL];
	logic [Y_W-1:0] pool_y [POOL];

	voxel_column_pole_detector dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	vcpd_pole_checker pole_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.query_count (query_count),
		.pole_count  (pole_count),
		.hit_count   (hit_count)
	);

	always #1 clk = ~clk;

	// True inside the window of the run where neither side idles at random.
	function automatic bit calm();
		return sent_total >= CALM_FROM && sent_total < CALM_TO;
	endfunction

	function automatic in_item_t make_item(logic [FUNC_W-1:0] f, logic [X_W-1:0] x,
			logic [Y_W-1:0] y, logic [Z_W-1:0] z);
		in_item_t it;
		it.func   = f;
		it.grid_x = x;
		it.grid_y = y;
		it.grid_z = z;
		return it;
	endfunction

	// Mostly a column of the pool, now and then any column of the grid.
	task automatic pick_column(output logic [X_W-1:0] x, output logic [Y_W-1:0] y);
		int k;
		if ($urandom_range(0, 9) == 0) begin
			x = X_W'($urandom);
			y = Y_W'($urandom);
		end else begin
			k = $urandom_range(0, POOL - 1);
			x = pool_x[k];
			y = pool_y[k];
		end
	endtask

	// Offers one item beat and returns at the rising edge that took it. The
	// push line is left high so that a following beat can go out back to back;
	// full is sampled on the falling edge, where it is settled for the edge to
	// come. Outside the calm window an idle gap comes before about a quarter of beats.
	task automatic offer_voxel_item(input in_item_t it);
		bit taken;
		if (!calm() && $urandom_range(0, 99) < 25) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push  <= 1'b1;
		item  <= it;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end
		sent_total++;
	endtask

	// One register beat; cfg_valid stays high for a following write.
	task automatic write_span_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [SPAN_W-1:0] val);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
	endtask

	task automatic set_spans(input logic [SPAN_W-1:0] lo, input logic [SPAN_W-1:0] hi);
		write_span_reg(REG_MIN_SPAN, lo);
		write_span_reg(REG_MAX_SPAN, hi);
		cfg_valid <= 1'b0;
	endtask

	// Stops offering items and waits until every expected result has been
	// popped, then lets the back end run dry before anything else happens.
	task automatic settle();
		push <= 1'b0;
		wait (pending == 0);
		@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// A well-formed column sequence: usually a clear, then a solid run, some
	// scattered cells or both, then a few queries, half of them aimed inside
	// the run. Scattered cells below the run break the lowest-cell rule; now
	// and then the run fills the whole column.
	task automatic build_column_sequence();
		logic [X_W-1:0] x;
		logic [Y_W-1:0] y;
		int             lo, hi, qz, shape;
		pick_column(x, y);
		if ($urandom_range(0, 4) != 0)
			offer_voxel_item(make_item(FUNC_CLEAR, x, y, Z_W'($urandom)));
		lo = $urandom_range(0, GRID_Z - 1);
		hi = lo + $urandom_range(0, 10);
		if ($urandom_range(0, 9) == 0) begin
			lo = 0;
			hi = GRID_Z - 1;
		end
		if (hi > GRID_Z - 1)
			hi = GRID_Z - 1;
		shape = $urandom_range(0, 2);
		if (shape != 1) begin
			for (int z = lo; z <= hi; z++)
				offer_voxel_item(make_item(FUNC_INSERT, x, y, Z_W'(z)));
		end
		if (shape != 0) begin
			repeat ($urandom_range(1, 5))
				offer_voxel_item(make_item(FUNC_INSERT, x, y,
					Z_W'($urandom_range(0, GRID_Z - 1))));
		end
		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 1))
				qz = $urandom_range(lo, hi);
			else
				qz = $urandom_range(0, GRID_Z - 1);
			offer_voxel_item(make_item(FUNC_QUERY, x, y, Z_W'(qz)));
		end
	endtask

	// Popping side. It idles about a quarter of the time, never inside the calm
	// window, and holds off once for a long stretch while items keep coming.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && sent_total >= HOLD_AT) begin
				held = 1'b1;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				pop <= calm() || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// Item side and verdict.
	initial begin
		logic [X_W-1:0] nx;
		logic [Y_W-1:0] ny;
		int             phase_start;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items, with the span registers at their reset values of
		// 4 and 31. The block sweeps its store after reset, so the first beat
		// waits out that pass on the full flag.
		// A query of a column that was never written answers all zero.
		offer_voxel_item(make_item(FUNC_QUERY, 5, 9, 0));
		// A lone cell at the lowest corner: span 0, too short for a pole.
		offer_voxel_item(make_item(FUNC_INSERT, 0, 0, 0));
		offer_voxel_item(make_item(FUNC_QUERY, 0, 0, 0));
		// A run of span 4 at the top of the far corner column is a pole; the
		// top cell lies in it, the cell just below it does not.
		for (int z = 27; z < GRID_Z; z++)
			offer_voxel_item(make_item(FUNC_INSERT, 63, 63, Z_W'(z)));
		offer_voxel_item(make_item(FUNC_QUERY, 63, 63, 31));
		offer_voxel_item(make_item(FUNC_QUERY, 63, 63, 26));
		// The unused code must leave the column as it was.
		offer_voxel_item(make_item(FUNC_UNUSED, 63, 63, 0));
		offer_voxel_item(make_item(FUNC_QUERY, 63, 63, 0));
		// A stray cell below the run: the run no longer starts at the lowest
		// occupied cell, so the column stops being a pole.
		offer_voxel_item(make_item(FUNC_INSERT, 63, 63, 20));
		offer_voxel_item(make_item(FUNC_QUERY, 63, 63, 30));
		// Clearing the column empties it again.
		offer_voxel_item(make_item(FUNC_CLEAR, 63, 63, 31));
		offer_voxel_item(make_item(FUNC_QUERY, 63, 63, 31));
		// Two runs of equal span: the upper one is reported.
		offer_voxel_item(make_item(FUNC_INSERT, 1, 2, 0));
		offer_voxel_item(make_item(FUNC_INSERT, 1, 2, 1));
		offer_voxel_item(make_item(FUNC_INSERT, 1, 2, 5));
		offer_voxel_item(make_item(FUNC_INSERT, 1, 2, 6));
		offer_voxel_item(make_item(FUNC_QUERY, 1, 2, 5));

		// Random phases. Each new span setting is written only once the block
		// has handed back every result, so the registers change while idle.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				settle();
				case (p)
					1: set_spans(0, 31);
					2: set_spans(0, 0);
					3: set_spans(31, 31);
					// The least span above the greatest: nothing can pass.
					4: set_spans(12, 6);
					default: set_spans(SPAN_W'($urandom_range(0, 8)),
						SPAN_W'($urandom_range(4, 31)));
				endcase
			end
			for (int k = 0; k < POOL; k++) begin
				pool_x[k] = X_W'($urandom);
				pool_y[k] = Y_W'($urandom);
			end
			phase_start = sent_total;
			while (sent_total - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) != 0) begin
					build_column_sequence();
				end else begin
					// Noise: any code, including the unused one, anywhere.
					pick_column(nx, ny);
					offer_voxel_item(make_item(FUNC_W'($urandom_range(0, 3)), nx, ny,
						Z_W'($urandom_range(0, GRID_Z - 1))));
				end
			end
		end

		settle();
		$display("Covered %0d item beats under %0d span settings, with %0d queries,",
			sent_total, NUM_PHASES, query_count);
		$display("%0d of them on pole columns and %0d with the point inside the run.",
			pole_count, hit_count);
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#800000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/vcpd_pkg.sv
rtl/core/vcpd_front.sv
rtl/core/vcpd_scan.sv
rtl/core/vcpd_back.sv
rtl/core/voxel_column_pole_detector.sv
tb/vcpd_pole_checker.sv
tb/voxel_column_pole_detector_tb.sv
